>>> rtl/core/text_console_char_writer_top_defines.svh
// Assertion macros for the console writer.
// IMP checks a same-cycle implication, NXT checks the following cycle.
`ifndef TEXT_CONSOLE_CHAR_WRITER_TOP_DEFINES_SVH
`define TEXT_CONSOLE_CHAR_WRITER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define CTW_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define CTW_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define CTW_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define CTW_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> rtl/core/ctw_pkg.sv
package ctw_pkg;

  // Default screen geometry
  localparam int ROWS_DEF = 25;
  localparam int COLS_DEF = 80;

  // Field widths
  localparam int ACTION_W  = 2;
  localparam int CHAR_W    = 8;
  localparam int INDEX_W   = 11;
  localparam int OFFSET_W  = 11;
  localparam int ATTR_W    = 8;
  localparam int CELL_W    = ATTR_W + CHAR_W;
  localparam int CFG_IDX_W = 1;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_PUT     = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_CLEAR   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_READ    = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_RECOLOR = 2'd3;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam int                TAB_STEP = 4;

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_ATTR  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHOWN = 1'b1;
  localparam logic [ATTR_W-1:0]    ATTR_RST  = 8'h07;
  localparam logic                 SHOWN_RST = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic latch;
    logic exec;
    logic sweep_prime;
    logic sweep_step;
    logic load_out;
  } ctw_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [ACTION_W-1:0] act;
    logic                need_scroll;
    logic                sweep_last;
  } ctw_stat_t;

endpackage

>>> rtl/core/ctw_ram.sv
module ctw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/ctw_ctrl.sv
`include "text_console_char_writer_top_defines.svh"
module ctw_ctrl import ctw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  ctw_stat_t stat,
  output ctw_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_PRIME = 3'd2;
  localparam logic [2:0] S_SWEEP = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  // Sequence one item: execute, optional buffer sweep, then hand off result
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        cmd.latch = in_valid;
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        case (stat.act)
          ACT_PUT:  state_nxt = stat.need_scroll ? S_PRIME : S_DONE;
          ACT_READ: state_nxt = S_DONE;
          default:  state_nxt = S_PRIME;
        endcase
      end
      S_PRIME: begin
        cmd.sweep_prime = 1'b1;
        state_nxt       = S_SWEEP;
      end
      S_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold the result until the sink takes it
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  `CTW_ASSERT_IMP(a_out_rise_on_load, clk, rst_n, $rose(out_valid_r), $past(cmd.load_out), "result raised without load")
  `CTW_ASSERT_NXT(a_accept_to_exec, clk, rst_n, in_valid && in_ready, state_r == S_EXEC, "accepted item not executed")

endmodule

>>> rtl/core/ctw_dpath.sv
`include "text_console_char_writer_top_defines.svh"
module ctw_dpath import ctw_pkg::*; #(
  parameter int ROWS = ROWS_DEF,
  parameter int COLS = COLS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ATTR_W-1:0]    cfg_data,
  input  logic [ACTION_W-1:0]  in_action,
  input  logic [CHAR_W-1:0]    in_char_code,
  input  logic [INDEX_W-1:0]   in_cell_index,
  input  ctw_cmd_t             cmd,
  output ctw_stat_t            stat,
  output logic [OFFSET_W-1:0]  out_cursor_offset,
  output logic [CELL_W-1:0]    out_cell_data
);

  localparam int CELLS = ROWS * COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = AW + 1;
  localparam int ROW_W = $clog2(ROWS);
  localparam int RW    = ROW_W + 1;
  localparam int COL_W = $clog2(COLS);
  localparam int NW    = COL_W + 3;
  localparam int IW    = (CW > INDEX_W) ? CW : INDEX_W;
  localparam int XW    = (CW > OFFSET_W) ? CW : OFFSET_W;

  localparam logic [1:0] SW_FILL    = 2'd0;
  localparam logic [1:0] SW_SCROLL  = 2'd1;
  localparam logic [1:0] SW_RECOLOR = 2'd2;

  // Configuration and cursor state
  logic [ATTR_W-1:0] attr_r;
  logic              shown_r;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;

  // Latched item
  logic [ACTION_W-1:0] act_r;
  logic [CHAR_W-1:0]   char_r;
  logic [INDEX_W-1:0]  idx_r;
  logic                hit_r;
  logic [1:0]          mode_r;
  logic [AW-1:0]       sw_idx_r, sw_idx_nxt;

  // Result register
  logic [OFFSET_W-1:0] out_offset_r, out_offset_nxt;
  logic [CELL_W-1:0]   out_data_r, out_data_nxt;

  // Derived values
  logic [IW-1:0]     idx_in_ext, idx_ext;
  logic [CW-1:0]     cur_addr, rd_base, rd_next, off_full;
  logic [XW-1:0]     off_x;
  logic [NW-1:0]     col_e, col_step;
  logic [RW-1:0]     row_e;
  logic              row_inc, put_store, put_scroll;
  logic [CELL_W-1:0] fill_cell;

  // RAM port
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;

  assign idx_in_ext = IW'(in_cell_index);
  assign idx_ext    = IW'(idx_r);
  assign cur_addr   = CW'(row_r) * CW'(COLS) + CW'(col_r);
  assign fill_cell  = {attr_r, CH_SPACE};
  assign rd_base    = (mode_r == SW_SCROLL) ? CW'(COLS) : '0;
  assign rd_next    = CW'(sw_idx_r) + rd_base + CW'(1);

  // Work out the cursor move for a put
  always_comb begin
    col_e     = NW'(col_r);
    col_step  = col_e;
    row_inc   = 1'b0;
    put_store = 1'b0;
    case (char_r)
      CH_BS: begin
        if (col_r != '0) begin
          col_step = col_e - NW'(1);
        end
      end
      CH_TAB: col_step = (col_e + NW'(TAB_STEP)) & ~NW'(TAB_STEP - 1);
      CH_CR:  col_step = '0;
      CH_LF: begin
        col_step = '0;
        row_inc  = 1'b1;
      end
      default: begin
        put_store = 1'b1;
        col_step  = col_e + NW'(1);
      end
    endcase
    // Wrap at line end
    if (col_step >= NW'(COLS)) begin
      col_step = '0;
      row_inc  = 1'b1;
    end
    row_e      = RW'(row_r) + RW'(row_inc);
    put_scroll = (row_e >= RW'(ROWS));
  end

  // Next cursor position
  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (cmd.exec) begin
      case (act_r)
        ACT_PUT: begin
          col_nxt = col_step[COL_W-1:0];
          if (!put_scroll) begin
            row_nxt = row_e[ROW_W-1:0];
          end
        end
        ACT_CLEAR: begin
          row_nxt = '0;
          col_nxt = '0;
        end
        default: ;
      endcase
    end
  end

  // Sweep index
  always_comb begin
    sw_idx_nxt = sw_idx_r;
    if (cmd.sweep_prime) begin
      sw_idx_nxt = '0;
    end else if (cmd.sweep_step) begin
      sw_idx_nxt = sw_idx_r + AW'(1);
    end
  end

  // Drive the cell buffer
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_addr[AW-1:0];
    ram_wdata = {attr_r, char_r};
    ram_re    = 1'b0;
    ram_raddr = idx_ext[AW-1:0];
    if (cmd.exec) begin
      if (act_r == ACT_PUT) begin
        ram_we = put_store;
      end
      if (act_r == ACT_READ) begin
        ram_re = hit_r;
      end
    end
    if (cmd.sweep_prime) begin
      ram_re    = 1'b1;
      ram_raddr = rd_base[AW-1:0];
    end
    if (cmd.sweep_step) begin
      ram_we    = 1'b1;
      ram_waddr = sw_idx_r;
      case (mode_r)
        SW_SCROLL:  ram_wdata = (CW'(sw_idx_r) < CW'(CELLS - COLS)) ? ram_rdata : fill_cell;
        SW_RECOLOR: ram_wdata = {attr_r, ram_rdata[CHAR_W-1:0]};
        default:    ram_wdata = fill_cell;
      endcase
      ram_re    = (rd_next < CW'(CELLS));
      ram_raddr = rd_next[AW-1:0];
    end
  end

  // Result for the finished item
  always_comb begin
    off_full       = shown_r ? cur_addr : CW'(CELLS);
    off_x          = XW'(off_full);
    out_offset_nxt = off_x[OFFSET_W-1:0];
    out_data_nxt   = (act_r == ACT_READ && hit_r) ? ram_rdata : '0;
  end

  // Configuration and cursor registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r  <= ATTR_RST;
      shown_r <= SHOWN_RST;
      row_r   <= '0;
      col_r   <= '0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_ATTR:  attr_r  <= cfg_data;
          CFG_SHOWN: shown_r <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // Item, sweep and result payload
  always_ff @(posedge clk) begin
    sw_idx_r <= sw_idx_nxt;
    if (cmd.latch) begin
      act_r  <= in_action;
      char_r <= in_char_code;
      idx_r  <= in_cell_index;
      hit_r  <= (idx_in_ext < IW'(CELLS));
    end
    if (cmd.exec) begin
      case (act_r)
        ACT_CLEAR:   mode_r <= SW_FILL;
        ACT_RECOLOR: mode_r <= SW_RECOLOR;
        default:     mode_r <= SW_SCROLL;
      endcase
    end
    if (cmd.load_out) begin
      out_offset_r <= out_offset_nxt;
      out_data_r   <= out_data_nxt;
    end
  end

  ctw_ram #(
    .WIDTH(CELL_W),
    .DEPTH(CELLS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign stat.act         = act_r;
  assign stat.need_scroll = (act_r == ACT_PUT) && put_scroll;
  assign stat.sweep_last  = (sw_idx_r == AW'(CELLS - 1));

  assign out_cursor_offset = out_offset_r;
  assign out_cell_data     = out_data_r;

  `CTW_ASSERT_IMP(a_row_range, clk, rst_n, 1'b1, RW'(row_r) < RW'(ROWS), "cursor row off screen")
  `CTW_ASSERT_IMP(a_col_range, clk, rst_n, 1'b1, NW'(col_r) < NW'(COLS), "cursor column off screen")
  `CTW_ASSERT_NXT(a_clear_home, clk, rst_n, cmd.exec && act_r == ACT_CLEAR, row_r == '0 && col_r == '0, "clear did not home cursor")

endmodule

>>> rtl/core/text_console_char_writer_top.sv
// Channel | Ports                                      | Direction
// cfg     | cfg_valid/ready, cfg_index, cfg_data       | in  (register writes)
// in      | in_valid/ready, in_action, in_char_code,   | in  (one item per transfer)
//         | in_cell_index                              |
// out     | out_valid/ready, out_cursor_offset,        | out (one result per item)
//         | out_cell_data                              |
//
// Put and read pass from transfer through the execute and done states to the
// result; the next item is taken on the cycle after the result is loaded.
// Scroll, clear and recolor add a prime state and a sweep: the cell buffer RAM is
// walked one cell per cycle through its single write port.
// Reset (rst_n low, synchronous) homes the cursor and loads the default
// attribute; the cell buffer is not cleared and holds garbage until written.
// A stalled output holds the finished item in its final state; a new item
// is still taken while a result waits to be read out.
module text_console_char_writer_top import ctw_pkg::*; #(
  parameter int ROWS = ROWS_DEF,
  parameter int COLS = COLS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ATTR_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [ACTION_W-1:0]  in_action,
  input  logic [CHAR_W-1:0]    in_char_code,
  input  logic [INDEX_W-1:0]   in_cell_index,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [OFFSET_W-1:0]  out_cursor_offset,
  output logic [CELL_W-1:0]    out_cell_data
);

  ctw_cmd_t  cmd;
  ctw_stat_t stat;

  // Register writes are always accepted; the port never stalls
  assign cfg_ready = 1'b1;

  ctw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ctw_dpath #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_action        (in_action),
    .in_char_code     (in_char_code),
    .in_cell_index    (in_cell_index),
    .cmd              (cmd),
    .stat             (stat),
    .out_cursor_offset(out_cursor_offset),
    .out_cell_data    (out_cell_data)
  );

endmodule

>>> sim/text_console_char_writer_top_tb.sv
import ctw_pkg::*;

// One predicted result of the console writer
typedef struct {
  logic [OFFSET_W-1:0] offset;
  logic [CELL_W-1:0]   data;
} console_result_t;

// Mirror of the console state; predicts one result per accepted item
class console_tracker;
  localparam int NROWS  = ROWS_DEF;
  localparam int NCOLS  = COLS_DEF;
  localparam int NCELLS = ROWS_DEF * COLS_DEF;

  logic [CELL_W-1:0] cells [NCELLS];
  int unsigned       row;
  int unsigned       col;
  logic [ATTR_W-1:0] attr;
  bit                shown;
  console_result_t   pending[$];
  int                errors;

  function new();
    row    = 0;
    col    = 0;
    attr   = ATTR_RST;
    shown  = SHOWN_RST;
    errors = 0;
    foreach (cells[i]) cells[i] = '0;
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [ATTR_W-1:0] val);
    if (idx == CFG_ATTR) attr = val;
    else if (idx == CFG_SHOWN) shown = val[0];
  endfunction

  // Apply one accepted item and queue its result
  function void note_item(logic [ACTION_W-1:0] act, logic [CHAR_W-1:0] ch,
                          logic [INDEX_W-1:0] idx);
    console_result_t res;
    logic [31:0]     off;
    res.data = '0;
    case (act)
      ACT_PUT: begin
        if (ch == CH_BS) begin
          if (col != 0) col = col - 1;
        end else if (ch == CH_TAB) begin
          col = (col + TAB_STEP) & ~(TAB_STEP - 1);
        end else if (ch == CH_CR) begin
          col = 0;
        end else if (ch == CH_LF) begin
          col = 0;
          row = row + 1;
        end else begin
          cells[row * NCOLS + col] = {attr, ch};
          col = col + 1;
        end
        if (col >= NCOLS) begin
          col = 0;
          row = row + 1;
        end
        // Scroll up one line, blank the bottom line
        while (row >= NROWS) begin
          for (int i = 0; i < NCELLS - NCOLS; i++) cells[i] = cells[i + NCOLS];
          for (int i = NCELLS - NCOLS; i < NCELLS; i++) cells[i] = {attr, CH_SPACE};
          row = row - 1;
        end
      end
      ACT_CLEAR: begin
        foreach (cells[i]) cells[i] = {attr, CH_SPACE};
        row = 0;
        col = 0;
      end
      ACT_READ: begin
        if (idx < NCELLS) res.data = cells[idx];
      end
      default: begin
        foreach (cells[i]) cells[i] = {attr, cells[i][CHAR_W-1:0]};
      end
    endcase
    off = shown ? row * NCOLS + col : NCELLS;
    res.offset = off[OFFSET_W-1:0];
    pending.push_back(res);
  endfunction

  // Compare one transfer on the result channel with the oldest prediction
  function void check_result(logic [OFFSET_W-1:0] offset, logic [CELL_W-1:0] cell_val);
    console_result_t exp_res;
    if (pending.size() == 0) begin
      $error("unexpected result: cursor_offset %0d cell_data 0x%04h", offset, cell_val);
      errors++;
      return;
    end
    exp_res = pending.pop_front();
    if (offset !== exp_res.offset) begin
      $error("cursor_offset: expected %0d, actual %0d", exp_res.offset, offset);
      errors++;
    end
    if (cell_val !== exp_res.data) begin
      $error("cell_data: expected 0x%04h, actual 0x%04h", exp_res.data, cell_val);
      errors++;
    end
  endfunction
endclass

module text_console_char_writer_top_tb;
  localparam int NCELLS      = ROWS_DEF * COLS_DEF;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 235;
  localparam int LONG_HOLD   = 3000;
  localparam int TAIL_CYCLES = 100;
  localparam longint CYCLE_LIMIT = 20_000_000;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ATTR_W-1:0]    cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [ACTION_W-1:0]  in_action;
  logic [CHAR_W-1:0]    in_char_code;
  logic [INDEX_W-1:0]   in_cell_index;
  logic                 out_valid;
  logic                 out_ready;
  logic [OFFSET_W-1:0]  out_cursor_offset;
  logic [CELL_W-1:0]    out_cell_data;

  console_tracker tracker = new();
  bit             burst;
  bit             hold_out;
  longint         cycles;

  text_console_char_writer_top u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_action         (in_action),
    .in_char_code      (in_char_code),
    .in_cell_index     (in_cell_index),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_cursor_offset (out_cursor_offset),
    .out_cell_data     (out_cell_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Abort a hung run
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Optional idle gap, then offer one item and hold it until transfer
  task automatic send_item(input logic [ACTION_W-1:0] act, input logic [CHAR_W-1:0] ch,
                           input logic [INDEX_W-1:0] idx);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= act;
    in_char_code  <= ch;
    in_cell_index <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.note_item(act, ch, idx);
  endtask

  // Stop offering and wait until every predicted result has arrived
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending.size() != 0) @(posedge clk);
  endtask

  // Write both registers back to back; valid stays high across the pair
  task automatic set_registers(input logic [ATTR_W-1:0] attr_val, input bit shown_val);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_ATTR;
    cfg_data  <= attr_val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.write_reg(CFG_ATTR, attr_val);
    cfg_index <= CFG_SHOWN;
    cfg_data  <= {{(ATTR_W-1){1'b0}}, shown_val};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.write_reg(CFG_SHOWN, {{(ATTR_W-1){1'b0}}, shown_val});
    cfg_valid <= 1'b0;
  endtask

  // Mostly cells on screen, some past the end
  function automatic logic [INDEX_W-1:0] pick_index();
    if ($urandom_range(0, 9) == 0) return INDEX_W'($urandom_range(NCELLS, 2**INDEX_W - 1));
    return INDEX_W'($urandom_range(0, NCELLS - 1));
  endfunction

  // Random bytes with a share of control codes; lf_pct sets newline weight
  function automatic logic [CHAR_W-1:0] pick_char(int lf_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < lf_pct) return CH_LF;
    if (r < lf_pct + 3) return CH_CR;
    if (r < lf_pct + 8) return CH_TAB;
    if (r < lf_pct + 13) return CH_BS;
    return CHAR_W'($urandom_range(0, 255));
  endfunction

  // Result side: random stalls, one long hold-off on request
  initial begin : result_sink
    int wait_cycles;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_out) begin
        wait_cycles = LONG_HOLD;
        hold_out    = 1'b0;
      end else begin
        wait_cycles = burst ? 0 : $urandom_range(0, 5);
      end
      if (wait_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      tracker.check_result(out_cursor_offset, out_cell_data);
    end
  end

  initial begin : stimulus
    logic [ATTR_W-1:0] phase_attr [PHASES];
    bit                phase_shown [PHASES];
    bit                lf_heavy;
    logic [ATTR_W-1:0] attr_val;
    int                r;
    phase_attr  = '{8'h1E, 8'h00, 8'hFF, 8'h00, 8'h70, 8'h00, 8'hFF, 8'h00};
    phase_shown = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
    burst    = 1'b0;
    hold_out = 1'b0;
    rst_n         <= 1'b0;
    cfg_valid     <= 1'b0;
    cfg_index     <= CFG_ATTR;
    cfg_data      <= '0;
    in_valid      <= 1'b0;
    in_action     <= ACT_PUT;
    in_char_code  <= '0;
    in_cell_index <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: the buffer is cleared first so every later on-screen read hits a written cell
    send_item(ACT_CLEAR,   8'h00,    '0);
    send_item(ACT_PUT,     8'h41,    '0);
    send_item(ACT_PUT,     8'h00,    '1);
    send_item(ACT_PUT,     8'hFF,    '0);
    send_item(ACT_READ,    8'h00,    11'd0);
    send_item(ACT_READ,    8'hFF,    11'd2);
    send_item(ACT_PUT,     CH_BS,    '0);
    send_item(ACT_PUT,     CH_CR,    '0);
    send_item(ACT_PUT,     CH_BS,    '0);
    send_item(ACT_PUT,     CH_TAB,   '0);
    send_item(ACT_PUT,     CH_TAB,   '0);
    send_item(ACT_PUT,     CH_SPACE, '0);
    send_item(ACT_PUT,     CH_LF,    '0);
    send_item(ACT_READ,    8'h00,    11'(NCELLS - 1));
    send_item(ACT_READ,    8'h00,    11'(NCELLS));
    send_item(ACT_READ,    8'h00,    '1);
    send_item(ACT_RECOLOR, 8'h00,    '0);
    send_item(ACT_READ,    8'h00,    11'd1);
    send_item(ACT_READ,    8'h00,    11'd8);
    send_item(ACT_PUT,     8'h7F,    '0);
    send_item(ACT_CLEAR,   8'h00,    '0);
    wait_idle();

    // Random phases, registers rewritten between them while idle
    for (int p = 0; p < PHASES; p++) begin
      attr_val = phase_attr[p];
      if (p == 3 || p == 5) attr_val = ATTR_W'($urandom_range(0, 255));
      set_registers(attr_val, phase_shown[p]);
      lf_heavy = (p == 1 || p == 3 || p == 5);
      burst    = (p == 2 || p == 5);
      if (p == 1) hold_out = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(0, 199);
        if (lf_heavy && n < 30) send_item(ACT_PUT, CH_LF, pick_index());
        else if (r < 1) send_item(ACT_CLEAR, CHAR_W'($urandom_range(0, 255)), pick_index());
        else if (r < 3) send_item(ACT_RECOLOR, CHAR_W'($urandom_range(0, 255)), pick_index());
        else if (r < 33) send_item(ACT_READ, CHAR_W'($urandom_range(0, 255)), pick_index());
        else send_item(ACT_PUT, pick_char(lf_heavy ? 20 : 5), pick_index());
      end
      wait_idle();
    end

    // Let any stray result show up before the verdict
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/ctw_pkg.sv
rtl/core/ctw_ram.sv
rtl/core/ctw_ctrl.sv
rtl/core/ctw_dpath.sv
rtl/core/text_console_char_writer_top.sv
sim/text_console_char_writer_top_tb.sv
